@@ sv/dwd_pkg.sv @@
// Shared types and constants for the diagonal weighted distance core.
package dwd_pkg;

  localparam int FRAC_BITS_DEF = 8;

  // Accumulator, radicand, root and shared subtractor widths.
  localparam int ACC_W  = 49;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;
  localparam int DIV_W  = 16;
  localparam int SUB_W  = 27;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } op_t;

  typedef struct packed {
    logic go;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } status_t;

endpackage

@@ sv/dwd_iter_unit.sv @@
// Iterative unit: restoring division or digit-by-digit square root on one subtractor.
module dwd_iter_unit #(
  parameter int QW = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dwd_pkg::cmd_t                 cmd,
  input  logic [QW-1:0]                 dividend,
  input  logic [dwd_pkg::DIV_W-1:0]     divisor,
  input  logic [dwd_pkg::RAD_W-1:0]     radicand,
  output dwd_pkg::status_t              st,
  output logic [QW-1:0]                 result
);

  localparam int SRC_W = (QW > dwd_pkg::RAD_W) ? QW : dwd_pkg::RAD_W;
  localparam int CW    = $clog2(SRC_W + 1);
  localparam int SW    = dwd_pkg::SUB_W;

  logic [SRC_W-1:0] src;
  logic [SW-1:0]    rem;
  logic [QW-1:0]    res;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  dwd_pkg::op_t     op;

  logic [SW-1:0]    rem_sh;
  logic [SW-1:0]    operand;
  logic [SW:0]      trial;
  logic             ge;

  // One trial subtraction per cycle, shared by both operations.
  always_comb begin
    if (op == dwd_pkg::OP_DIV) begin
      rem_sh  = {rem[SW-2:0], src[SRC_W-1]};
      operand = SW'(divisor);
    end else begin
      rem_sh  = {rem[SW-3:0], src[SRC_W-1:SRC_W-2]};
      operand = SW'({res[dwd_pkg::ROOT_W-1:0], 2'b01});
    end
    trial = {1'b0, rem_sh} - {1'b0, operand};
    ge    = ~trial[SW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= dwd_pkg::OP_DIV;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        op   <= cmd.op;
        busy <= 1'b1;
        rem  <= '0;
        res  <= '0;
        if (cmd.op == dwd_pkg::OP_DIV) begin
          src <= SRC_W'(dividend) << (SRC_W - QW);
          cnt <= CW'(QW);
        end else begin
          src <= SRC_W'(radicand) << (SRC_W - dwd_pkg::RAD_W);
          cnt <= CW'(dwd_pkg::ROOT_W);
        end
      end else if (busy) begin
        rem <= ge ? trial[SW-1:0] : rem_sh;
        res <= {res[QW-2:0], ge};
        src <= (op == dwd_pkg::OP_DIV) ? (src << 1) : (src << 2);
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign st.busy = busy;
  assign st.done = done;
  assign result  = res;

endmodule

@@ sv/diagonal_weighted_distance_core.sv @@
// Top level of the diagonal weighted distance core: sequencer, accumulator and result word.
//
// Each input word carries one dimension of a vector pair: coord_a, coord_b and
// that dimension's variance, all signed fixed point with FRAC_BITS fraction
// bits, and last_dim marking the final dimension. The core squares the
// difference, divides it by the variance magnitude and adds the quotient,
// signed as the variance, to a saturating 49-bit accumulator.
// On the last dimension one output word follows: the floor square root of the
// sum (zero when the sum is not positive) and a flag that the sum clamped.
// Each word passes, from its acceptance to the next possible acceptance, through
// the accept cycle, a cycle that forms the square and starts the unit,
// 32 + FRAC_BITS restoring division steps, a cycle in which the unit reports
// completion and an accumulate cycle. A last word with a positive sum adds a
// start cycle, 24 two-bit square root steps on the same subtractor, a
// completion cycle and the cycle that loads the output register; with a sum
// that is not positive only that load is added. The output word appears in the
// same cycle as in_ready returns.
// The output word sits in its own register; the next input word is accepted
// while it waits. in_ready is high only in the idle state, and when a further
// result is ready while the receiver still stalls, the core waits in its final state.
// Synchronous reset clears the accumulator, the flag and out_valid.
module diagonal_weighted_distance_core #(
  parameter int FRAC_BITS = dwd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                coord_a,
  input  logic signed [15:0]                coord_b,
  input  logic signed [15:0]                variance,
  input  logic                              last_dim,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dwd_pkg::ROOT_W-1:0]        distance,
  output logic                              saturated
);

  // Quotient width: a 32-bit square shifted up by the fraction bits.
  localparam int QW = 32 + FRAC_BITS;
  localparam int AW = dwd_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ACC,
    S_ROOT_GO,
    S_ROOT,
    S_DONE
  } state_t;

  state_t                       state;
  logic [15:0]                  mag;
  logic [dwd_pkg::DIV_W-1:0]    dvsr;
  logic                         neg;
  logic                         last;
  logic [AW-1:0]                sum;
  logic                         sat_seen;
  logic [dwd_pkg::ROOT_W-1:0]   root_val;

  dwd_pkg::cmd_t                cmd;
  dwd_pkg::status_t             st;
  logic [QW-1:0]                quot;
  logic [QW-1:0]                dividend;
  logic [31:0]                  sq;

  logic signed [16:0]           diff;
  logic [AW-1:0]                term;
  logic [AW:0]                  s_ext;
  logic                         ovf;
  logic [AW-1:0]                s_clamped;

  // The difference of two 16-bit coordinates never exceeds 65535 in magnitude,
  // so 16 unsigned bits hold it; the square then fits in 32 bits.
  assign diff = 17'(coord_a) - 17'(coord_b);

  assign sq       = 32'(mag) * 32'(mag);
  assign dividend = QW'(sq) << FRAC_BITS;

  // The quotient takes the sign of the variance; an overflowing sum clamps to
  // whichever end of the range it ran past.
  always_comb begin
    term      = neg ? (AW'(0) - AW'(quot)) : AW'(quot);
    s_ext     = {sum[AW-1], sum} + {term[AW-1], term};
    ovf       = s_ext[AW] != s_ext[AW-1];
    s_clamped = ovf ? (s_ext[AW] ? dwd_pkg::ACC_MIN : dwd_pkg::ACC_MAX) : s_ext[AW-1:0];
  end

  // The division is started in the cycle the square is formed; the unit's
  // source register is the register after the multiplier.
  always_comb begin
    cmd.go = (state == S_MUL) || (state == S_ROOT_GO);
    cmd.op = (state == S_ROOT_GO) ? dwd_pkg::OP_SQRT : dwd_pkg::OP_DIV;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In the final state the output register is reloaded instead.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag   <= diff[16] ? 16'(-diff) : diff[15:0];
            neg   <= variance[15];
            last  <= last_dim;
            if (variance == 16'sd0) begin
              dvsr <= 16'd1;
            end else if (variance[15]) begin
              dvsr <= 16'(-variance);
            end else begin
              dvsr <= variance;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (st.done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sum  <= s_clamped;
          if (ovf) begin
            sat_seen <= 1'b1;
          end
          root_val <= '0;
          if (!last) begin
            state <= S_IDLE;
          end else if (!s_clamped[AW-1] && (s_clamped != '0)) begin
            state <= S_ROOT_GO;
          end else begin
            state <= S_DONE;
          end
        end
        S_ROOT_GO: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (st.done) begin
            root_val <= quot[dwd_pkg::ROOT_W-1:0];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            distance  <= root_val;
            saturated <= sat_seen;
            out_valid <= 1'b1;
            sum       <= '0;
            sat_seen  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dwd_iter_unit #(
    .QW(QW)
  ) u_iter (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .dividend (dividend),
    .divisor  (dvsr),
    .radicand (sum[dwd_pkg::RAD_W-1:0]),
    .st       (st),
    .result   (quot)
  );

  // The shared unit is never restarted while it is still iterating.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.go |-> !st.busy)
    else $error("iterative unit started while busy");

  // A word is only taken when the unit is quiet.
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !st.busy)
    else $error("input word accepted while the unit is busy");

  // Completion of the unit is only seen while the sequencer waits for it.
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    st.done |-> (state == S_DIV || state == S_ROOT))
    else $error("unit finished outside a waiting state");

  // A new output word is only raised from the final state of a vector.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output word raised outside the final state");

  // The accumulator is empty whenever a result has just been loaded.
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> (sum == '0 && !sat_seen))
    else $error("accumulator not cleared after a result");

endmodule
